// File: hdl/pid_controller_clamped_defines.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

`ifndef SYNTHESIS
`define PIDC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pidc assertion failed");
`define PIDC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pidc forbidden condition");
`else
`define PIDC_ASSERT(lbl, clk, rst_n, prop)
`define PIDC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: hdl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int TEMP_W  = 16;
  localparam int GAIN_W  = 24;
  localparam int LIM_W   = 20;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int SUM_W   = 22;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PP_W    = GAIN_W + ERR_W;
  localparam int PI_W    = GAIN_W + SUM_W;
  localparam int PD_W    = GAIN_W + DIFF_W;
  localparam int ACC_W   = PI_W + 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = 3;

  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 24'd197;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 24'd0;
  localparam logic [TEMP_W-1:0] DRIVE_MIN_RST = 16'd0;
  localparam logic [TEMP_W-1:0] DRIVE_MAX_RST = 16'd25600;
  localparam logic [LIM_W-1:0]  INT_LIM_RST   = 20'd51200;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DRIVE_MIN = 3'd3,
    REG_DRIVE_MAX = 3'd4,
    REG_INT_LIM   = 3'd5
  } pidc_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [TEMP_W-1:0] drive_min;
    logic signed [TEMP_W-1:0] drive_max;
    logic        [LIM_W-1:0]  integral_limit;
  } pidc_cfg_t;

endpackage

// File: hdl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// Clamped positional PID controller
// Each input word (setpoint, measurement, signed Q8.8) yields one drive word
// (signed Q8.8) through a pipeline of an input register, the error and
// clamped-integral stage, three registered 24-bit gain products, the product
// sum, and the shift and drive clamp. A new word is taken every cycle unless
// an output stall backs up a full pipeline; the rate is set by the integral
// feedback, whose add and clamp are combinational. Gains are signed with
// GAIN_FRAC_BITS fraction bits, the integral is clamped to plus or minus
// integral_limit, and drive_min wins over drive_max if the two cross.
// Registers sit on the APB port at byte addresses 0x00 to 0x14 and are to be
// written only while no word is in flight.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_defines.svh"

module pid_controller_clamped import pidc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [TEMP_W-1:0] target_temp_i,
  input  logic signed [TEMP_W-1:0] measured_temp_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [TEMP_W-1:0] drive_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int NSTG = 5;

  pidc_cfg_t                cfg;
  logic [NSTG-1:0]          vld_d;
  logic [NSTG-1:0]          vld_q;
  logic [NSTG:0]            rdy;
  logic [NSTG-1:0]          prv;
  logic [NSTG-1:0]          ld;
  logic signed [TEMP_W-1:0] tgt_q;
  logic signed [TEMP_W-1:0] meas_q;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;
  logic signed [PD_W-1:0]   prod_d;

  assign prv = {vld_q[NSTG-2:0], in_valid_i};

  always_comb begin
    rdy[NSTG] = ~out_stall_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign ld    = rdy[NSTG-1:0] & prv;
  assign vld_d = (rdy[NSTG-1:0] & prv) | (~rdy[NSTG-1:0] & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      tgt_q  <= target_temp_i;
      meas_q <= measured_temp_i;
    end
  end

  assign in_stall_o  = ~rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

  pidc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidc_err u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ld_i             (ld[1]),
    .target_temp_i    (tgt_q),
    .measured_temp_i  (meas_q),
    .integral_limit_i (cfg.integral_limit),
    .err_o            (err),
    .sum_o            (sum),
    .diff_o           (diff)
  );

  pidc_mul u_mul (
    .clk_i    (clk_i),
    .ld_i     (ld[2]),
    .cfg_i    (cfg),
    .err_i    (err),
    .sum_i    (sum),
    .diff_i   (diff),
    .prod_p_o (prod_p),
    .prod_i_o (prod_i),
    .prod_d_o (prod_d)
  );

  pidc_clamp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_clamp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_acc_i (ld[3]),
    .ld_out_i (ld[4]),
    .cfg_i    (cfg),
    .prod_p_i (prod_p),
    .prod_i_i (prod_i),
    .prod_d_i (prod_d),
    .drive_o  (drive_o)
  );

  `PIDC_ASSERT_NEVER(a_stall_only_full, clk_i, rst_ni, in_stall_o && (vld_q != '1))

endmodule

// File: hdl/pidc_cfg.sv
// ----------------------------------------------------------------------------
// PID controller register file
// APB write and read access to the gains, drive clamps and integral limit.
// ----------------------------------------------------------------------------
module pidc_cfg import pidc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output pidc_cfg_t         cfg_o
);

  pidc_cfg_t cfg_q;
  pidc_reg_e idx;
  logic      wr_en;

  assign idx    = pidc_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= GAIN_P_RST;
      cfg_q.gain_i         <= GAIN_I_RST;
      cfg_q.gain_d         <= GAIN_D_RST;
      cfg_q.drive_min      <= DRIVE_MIN_RST;
      cfg_q.drive_max      <= DRIVE_MAX_RST;
      cfg_q.integral_limit <= INT_LIM_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:    cfg_q.gain_p         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg_q.gain_i         <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg_q.gain_d         <= pwdata[GAIN_W-1:0];
        REG_DRIVE_MIN: cfg_q.drive_min      <= pwdata[TEMP_W-1:0];
        REG_DRIVE_MAX: cfg_q.drive_max      <= pwdata[TEMP_W-1:0];
        REG_INT_LIM:   cfg_q.integral_limit <= pwdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:    prdata = DATA_W'(unsigned'(cfg_q.gain_p));
      REG_GAIN_I:    prdata = DATA_W'(unsigned'(cfg_q.gain_i));
      REG_GAIN_D:    prdata = DATA_W'(unsigned'(cfg_q.gain_d));
      REG_DRIVE_MIN: prdata = DATA_W'(unsigned'(cfg_q.drive_min));
      REG_DRIVE_MAX: prdata = DATA_W'(unsigned'(cfg_q.drive_max));
      REG_INT_LIM:   prdata = DATA_W'(cfg_q.integral_limit);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hdl/pidc_err.sv
// ----------------------------------------------------------------------------
// PID controller error stage
// Forms the error, updates the clamped integral and the error difference.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_defines.svh"

module pidc_err import pidc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ld_i,
  input  logic signed [TEMP_W-1:0] target_temp_i,
  input  logic signed [TEMP_W-1:0] measured_temp_i,
  input  logic        [LIM_W-1:0]  integral_limit_i,
  output logic signed [ERR_W-1:0]  err_o,
  output logic signed [SUM_W-1:0]  sum_o,
  output logic signed [DIFF_W-1:0] diff_o
);

  logic signed [ERR_W-1:0]  err_d;
  logic signed [ERR_W-1:0]  last_error_q;
  logic signed [SUM_W-1:0]  sum_raw;
  logic signed [SUM_W-1:0]  lim_pos;
  logic signed [SUM_W-1:0]  lim_neg;
  logic signed [SUM_W-1:0]  error_sum_d;
  logic signed [SUM_W-1:0]  error_sum_q;
  logic signed [DIFF_W-1:0] diff_d;
  logic signed [DIFF_W-1:0] diff_q;

  assign err_d   = ERR_W'(target_temp_i) - ERR_W'(measured_temp_i);
  assign sum_raw = error_sum_q + SUM_W'(err_d);
  assign lim_pos = $signed(SUM_W'(integral_limit_i));
  assign lim_neg = -lim_pos;
  assign diff_d  = DIFF_W'(err_d) - DIFF_W'(last_error_q);

  always_comb begin
    priority if (sum_raw > lim_pos) begin
      error_sum_d = lim_pos;
    end else if (sum_raw < lim_neg) begin
      error_sum_d = lim_neg;
    end else begin
      error_sum_d = sum_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (ld_i) begin
      error_sum_q  <= error_sum_d;
      last_error_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      diff_q <= diff_d;
    end
  end

  // The state registers hold the values of the word sitting in this stage.
  assign err_o  = last_error_q;
  assign sum_o  = error_sum_q;
  assign diff_o = diff_q;

  `PIDC_ASSERT(a_sum_in_limit, clk_i, rst_ni,
    ld_i |=> (error_sum_q <= lim_pos) && (error_sum_q >= lim_neg))
  `PIDC_ASSERT(a_diff_tracks, clk_i, rst_ni,
    ld_i |=> diff_q == (DIFF_W'(last_error_q) - DIFF_W'($past(last_error_q))))

endmodule

// File: hdl/pidc_mul.sv
// ----------------------------------------------------------------------------
// PID controller multiplier stage
// Three parallel gain products, each registered.
// ----------------------------------------------------------------------------
module pidc_mul import pidc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     ld_i,
  input  pidc_cfg_t                cfg_i,
  input  logic signed [ERR_W-1:0]  err_i,
  input  logic signed [SUM_W-1:0]  sum_i,
  input  logic signed [DIFF_W-1:0] diff_i,
  output logic signed [PP_W-1:0]   prod_p_o,
  output logic signed [PI_W-1:0]   prod_i_o,
  output logic signed [PD_W-1:0]   prod_d_o
);

  logic signed [PP_W-1:0] prod_p_d;
  logic signed [PI_W-1:0] prod_i_d;
  logic signed [PD_W-1:0] prod_d_d;
  logic signed [PP_W-1:0] prod_p_q;
  logic signed [PI_W-1:0] prod_i_q;
  logic signed [PD_W-1:0] prod_d_q;

  assign prod_p_d = PP_W'($signed(cfg_i.gain_p)) * PP_W'(err_i);
  assign prod_i_d = PI_W'($signed(cfg_i.gain_i)) * PI_W'(sum_i);
  assign prod_d_d = PD_W'($signed(cfg_i.gain_d)) * PD_W'(diff_i);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  assign prod_p_o = prod_p_q;
  assign prod_i_o = prod_i_q;
  assign prod_d_o = prod_d_q;

endmodule

// File: hdl/pidc_clamp.sv
// ----------------------------------------------------------------------------
// PID controller output stage
// Sums the products, drops the gain fraction and clamps the drive.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_defines.svh"

module pidc_clamp import pidc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ld_acc_i,
  input  logic                     ld_out_i,
  input  pidc_cfg_t                cfg_i,
  input  logic signed [PP_W-1:0]   prod_p_i,
  input  logic signed [PI_W-1:0]   prod_i_i,
  input  logic signed [PD_W-1:0]   prod_d_i,
  output logic signed [TEMP_W-1:0] drive_o
);

  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  lo;
  logic signed [ACC_W-1:0]  hi;
  logic signed [ACC_W-1:0]  y_hi;
  logic signed [ACC_W-1:0]  y_lo;
  logic signed [TEMP_W-1:0] drive_q;

  assign acc_d   = ACC_W'(prod_p_i) + ACC_W'(prod_i_i) + ACC_W'(prod_d_i);
  assign shifted = acc_q >>> GAIN_FRAC_BITS;
  assign lo      = ACC_W'(cfg_i.drive_min);
  assign hi      = ACC_W'(cfg_i.drive_max);
  assign y_hi    = (shifted > hi) ? hi : shifted;
  assign y_lo    = (y_hi < lo) ? lo : y_hi;

  always_ff @(posedge clk_i) begin
    if (ld_acc_i) begin
      acc_q <= acc_d;
    end
    if (ld_out_i) begin
      drive_q <= y_lo[TEMP_W-1:0];
    end
  end

  assign drive_o = drive_q;

  `PIDC_ASSERT(a_drive_in_range, clk_i, rst_ni,
    ld_out_i && (lo <= hi) |=> (ACC_W'(drive_o) >= lo) && (ACC_W'(drive_o) <= hi))

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Clamped PID controller testbench
// Streams setpoint and measurement words through the controller under many
// register settings and checks every drive word against a scoreboard that
// tracks the clamped integral and the previous error. The input and output
// sides idle and stall at random in the first two of three phases, not in the third.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pidc_pkg::*;

  localparam int FRAC_BITS        = 16;
  localparam int SETTLE_CYCLES    = 10;
  localparam int SEGMENTS         = 12;
  localparam int SEGMENT_READINGS = 140;
  localparam int SPARE_REG_LO     = 6;
  localparam int SPARE_REG_HI     = 7;

  typedef struct {
    logic signed [TEMP_W-1:0] target;
    logic signed [TEMP_W-1:0] measured;
  } reading_t;

  class drive_scoreboard;
    pidc_cfg_t                cfg;
    logic signed [SUM_W-1:0]  error_sum;
    logic signed [ERR_W-1:0]  last_error;
    logic signed [TEMP_W-1:0] expected_drive[$];
    int                       mismatches;
    int                       accepted;
    int                       checked;

    function new();
      cfg.gain_p         = GAIN_P_RST;
      cfg.gain_i         = GAIN_I_RST;
      cfg.gain_d         = GAIN_D_RST;
      cfg.drive_min      = DRIVE_MIN_RST;
      cfg.drive_max      = DRIVE_MAX_RST;
      cfg.integral_limit = INT_LIM_RST;
      error_sum  = '0;
      last_error = '0;
      mismatches = 0;
      accepted   = 0;
      checked    = 0;
    endfunction

    function void write_register(int idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_GAIN_P:    cfg.gain_p = value[GAIN_W-1:0];
        REG_GAIN_I:    cfg.gain_i = value[GAIN_W-1:0];
        REG_GAIN_D:    cfg.gain_d = value[GAIN_W-1:0];
        REG_DRIVE_MIN: cfg.drive_min = value[TEMP_W-1:0];
        REG_DRIVE_MAX: cfg.drive_max = value[TEMP_W-1:0];
        REG_INT_LIM:   cfg.integral_limit = value[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_reading(logic signed [TEMP_W-1:0] target,
                               logic signed [TEMP_W-1:0] measured);
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
      logic signed [SUM_W+1:0]  sum;
      logic signed [SUM_W+1:0]  lim;
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kd;
      logic signed [TEMP_W-1:0] lo;
      logic signed [TEMP_W-1:0] hi;
      logic signed [ACC_W-1:0]  acc;
      logic signed [ACC_W-1:0]  level;
      kp  = cfg.gain_p;
      ki  = cfg.gain_i;
      kd  = cfg.gain_d;
      lo  = cfg.drive_min;
      hi  = cfg.drive_max;
      lim = cfg.integral_limit;
      err = target - measured;
      sum = error_sum + err;
      if (sum > lim) begin
        sum = lim;
      end
      if (sum < -lim) begin
        sum = -lim;
      end
      error_sum = sum[SUM_W-1:0];
      diff  = err - last_error;
      acc   = kp * err + ki * error_sum + kd * diff;
      last_error = err;
      level = acc >>> FRAC_BITS;
      if (level > hi) begin
        level = hi;
      end
      if (level < lo) begin
        level = lo;
      end
      expected_drive.push_back(level[TEMP_W-1:0]);
      accepted++;
    endfunction

    function void check_drive(logic signed [TEMP_W-1:0] actual);
      logic signed [TEMP_W-1:0] want;
      checked++;
      if (expected_drive.size() == 0) begin
        $error("drive word with no reading pending: drive actual %0d", actual);
        mismatches++;
      end else begin
        want = expected_drive.pop_front();
        if (actual !== want) begin
          $error("drive mismatch: expected %0d, actual %0d", want, actual);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [TEMP_W-1:0] target_temp_i = '0;
  logic signed [TEMP_W-1:0] measured_temp_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [TEMP_W-1:0] drive_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  drive_scoreboard sb;
  reading_t        readings[$];
  int              send_idle = 32;
  int              recv_idle = 55;
  int              settings_applied = 0;

  pid_controller_clamped #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .target_temp_i  (target_temp_i),
    .measured_temp_i(measured_temp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_reading(target_temp_i, measured_temp_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (readings.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i      <= 1'b1;
          target_temp_i   <= readings[0].target;
          measured_temp_i <= readings[0].measured;
          readings.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_drive(drive_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  task automatic set_register(int idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    sb.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (readings.size() != 0 || in_valid_i || sb.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_reading(int target, int measured);
    reading_t r;
    r.target   = TEMP_W'(target);
    r.measured = TEMP_W'(measured);
    readings.push_back(r);
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return {8'($urandom_range(255)), 24'h7F_FFFF};
      1: return 32'h0080_0000;
      2: return '0;
      3: return $urandom;
      default: return DATA_W'(int'($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic logic [TEMP_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic reading_t random_reading();
    reading_t r;
    int       delta;
    case ($urandom_range(9))
      0, 1, 2: begin
        r.target   = TEMP_W'($urandom);
        r.measured = TEMP_W'($urandom);
      end
      3: begin
        r.target   = pick_extreme();
        r.measured = pick_extreme();
      end
      default: begin
        delta      = int'($urandom_range(1024)) - 512;
        r.target   = TEMP_W'(int'($urandom_range(16383)) - 4096);
        r.measured = TEMP_W'(int'(r.target) + delta);
      end
    endcase
    return r;
  endfunction

  task automatic randomize_settings();
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lim;
    case ($urandom_range(5))
      0: begin
        lo = 32'hFFFF_8000;
        hi = 32'h0000_7FFF;
      end
      1: begin
        lo = $urandom_range(20000, 1);
        hi = -int'($urandom_range(20000));
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = -int'($urandom_range(12800));
        hi = $urandom_range(25600);
      end
    endcase
    case ($urandom_range(5))
      0: lim = '0;
      1: lim = 32'h000F_FFFF;
      2: lim = $urandom;
      default: lim = $urandom_range(100000);
    endcase
    set_register(REG_GAIN_P, pick_gain());
    set_register(REG_GAIN_I, pick_gain());
    set_register(REG_GAIN_D, pick_gain());
    set_register(REG_DRIVE_MIN, lo);
    set_register(REG_DRIVE_MAX, hi);
    set_register(REG_INT_LIM, lim);
    if ($urandom_range(3) == 0) begin
      set_register($urandom_range(SPARE_REG_HI, SPARE_REG_LO), $urandom);
    end
    settings_applied++;
  endtask

  initial begin
    int left;
    int chunk;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: full-scale errors drive the integral into its clamp and
    // the drive into both output limits.
    settings_applied = 1;
    @(negedge clk_i);
    push_reading(0, 0);
    push_reading(32767, -32768);
    push_reading(32767, -32768);
    push_reading(-32768, 32767);
    push_reading(-32768, 32767);
    push_reading(32767, 32767);
    push_reading(-32768, -32768);
    push_reading(1, 0);
    push_reading(0, 1);
    wait_drained();

    // Largest gains with the widest integral and drive range, upper bits set.
    set_register(REG_GAIN_P, 32'hFF7F_FFFF);
    set_register(REG_GAIN_I, 32'hAB80_0000);
    set_register(REG_GAIN_D, 32'h007F_FFFF);
    set_register(REG_DRIVE_MIN, 32'hFFFF_8000);
    set_register(REG_DRIVE_MAX, 32'h1234_7FFF);
    set_register(REG_INT_LIM, 32'hFFFF_FFFF);
    settings_applied++;
    @(negedge clk_i);
    push_reading(32767, -32768);
    push_reading(32767, -32768);
    push_reading(32767, -32768);
    push_reading(-32768, 32767);
    push_reading(-32768, 32767);
    wait_drained();

    // The integral limit drops below the stored sum, the drive limits cross,
    // and writes to unmapped addresses must change nothing.
    set_register(REG_INT_LIM, '0);
    set_register(REG_DRIVE_MIN, 32'd1000);
    set_register(REG_DRIVE_MAX, 32'hFFFF_FC18);
    set_register(SPARE_REG_LO, 32'hFFFF_FFFF);
    set_register(SPARE_REG_HI, 32'hFFFF_FFFF);
    settings_applied++;
    @(negedge clk_i);
    push_reading(100, -100);
    push_reading(-100, 100);
    push_reading(0, 0);
    wait_drained();

    set_register(REG_GAIN_P, 32'h0080_0000);
    set_register(REG_GAIN_I, '0);
    set_register(REG_GAIN_D, 32'h0080_0000);
    set_register(REG_DRIVE_MIN, 32'hFFFF_8000);
    set_register(REG_DRIVE_MAX, 32'h0000_7FFF);
    set_register(REG_INT_LIM, 32'd256);
    settings_applied++;
    @(negedge clk_i);
    push_reading(0, 32767);
    push_reading(0, -32768);
    push_reading(5, 5);
    push_reading(-32768, 32767);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle = 32;
        recv_idle = 55;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle = 55;
        recv_idle = 32;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      randomize_settings();
      left = SEGMENT_READINGS;
      while (left > 0) begin
        chunk = $urandom_range(60, 15);
        if (chunk > left) begin
          chunk = left;
        end
        @(negedge clk_i);
        repeat (chunk) readings.push_back(random_reading());
        left -= chunk;
        if ($urandom_range(2) == 0) begin
          wait_drained();
        end else begin
          while (readings.size() > 2) begin
            @(negedge clk_i);
          end
        end
      end
      wait_drained();
    end

    $display("Checked %0d drive words from %0d readings under %0d register settings,",
             sb.checked, sb.accepted, settings_applied);
    $display("including full-scale errors, integral clamping and crossed drive limits.");
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for the controller.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
